// ===== sv/vbm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vbm_pkg
// Shared constants and types for the amplifier bank with frame mix.
// ----------------------------------------------------------------------------
package vbm_pkg;

    localparam int EXP_TABLE_BITS = 10;
    localparam int EXP_ROM_N      = (1 << EXP_TABLE_BITS) + 1;
    localparam int EXP_IDX_W      = EXP_TABLE_BITS + 1;

    localparam int CV_W = 15;
    localparam logic [CV_W-1:0] CV_FULL = 15'd20480;

    localparam int FAC_W  = 17;
    localparam int GAIN_W = 16;
    localparam int SUM_W  = 21;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIX_ONE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIX_TWO = 2'd2;

    typedef struct packed {
        logic [15:0]      audio;
        logic [FAC_W-1:0] lin_fac;
        logic             lin_en;
        logic [FAC_W-1:0] exp_fac;
        logic             exp_en;
        logic             last;
    } vbm_item_t;

    typedef struct packed {
        logic [GAIN_W-1:0] level;
        logic [GAIN_W-1:0] mix_one;
        logic [GAIN_W-1:0] mix_two;
    } vbm_gain_t;

endpackage
`default_nettype wire

// ===== sv/vbm_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vbm_front
// Accepts channel beats, clamps the control voltages and works out the
// linear factor and the interpolated exponential factor from the curve ROM.
// ----------------------------------------------------------------------------
module vbm_front (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [47:0]       in_data,
    input  wire logic [1:0]        in_user,
    input  wire logic              in_last,
    output logic                   push_valid,
    output vbm_pkg::vbm_item_t     push_item,
    input  wire logic              q_full
);
    import vbm_pkg::*;

    localparam int T_W    = CV_W + EXP_TABLE_BITS;
    localparam int IDX_SH = T_W + 15;
    localparam int M_W    = T_W + 1;
    localparam longint unsigned IDX_M_L = (64'd1 << IDX_SH) / 20480 + 1;
    localparam logic [M_W-1:0] IDX_M = M_W'(IDX_M_L);
    localparam logic [19:0] LIN_M = 20'd838861;
    localparam logic [22:0] INT_M = 23'd6710887;
    localparam logic [EXP_IDX_W-1:0] EXP_IDX_LAST = EXP_IDX_W'(EXP_ROM_N - 1);

    localparam logic [2:0] F_IDLE = 3'd0;
    localparam logic [2:0] F_IDX  = 3'd1;
    localparam logic [2:0] F_RD   = 3'd2;
    localparam logic [2:0] F_MUL  = 3'd3;
    localparam logic [2:0] F_FIN  = 3'd4;

    typedef logic [FAC_W-1:0] exp_rom_t [EXP_ROM_N];

    function automatic longint unsigned isqrt64(input longint unsigned v);
        longint unsigned res;
        longint unsigned bit_v;
        longint unsigned rem;
        res   = 64'd0;
        bit_v = 64'd1 << 62;
        rem   = v;
        for (int n = 0; n < 32; n++) begin
            if (bit_v > rem) begin
                bit_v = bit_v >> 2;
            end
        end
        for (int n = 0; n < 32; n++) begin
            if (bit_v != 64'd0) begin
                if (rem >= res + bit_v) begin
                    rem = rem - (res + bit_v);
                    res = (res >> 1) + bit_v;
                end else begin
                    res = res >> 1;
                end
                bit_v = bit_v >> 2;
            end
        end
        return res;
    endfunction

    function automatic exp_rom_t build_exp_rom();
        exp_rom_t        rom;
        longint unsigned roots [EXP_TABLE_BITS+1];
        longint unsigned p;
        longint unsigned e;
        roots[0] = 64'd50 << 24;
        for (int m = 1; m <= EXP_TABLE_BITS; m++) begin
            roots[m] = isqrt64(roots[m-1] << 24);
        end
        for (int k = 0; k < EXP_ROM_N; k++) begin
            p = 64'd1 << 24;
            for (int b = 0; b < EXP_TABLE_BITS; b++) begin
                if (((k >> b) & 1) == 1) begin
                    p = (p * roots[EXP_TABLE_BITS-b]) >> 24;
                end
            end
            e = (p - (64'd1 << 24) + 64'd6272) / 64'd12544;
            if (e > 64'd65536) begin
                e = 64'd65536;
            end
            if (k == 0) begin
                e = 64'd0;
            end
            if (k == EXP_ROM_N - 1) begin
                e = 64'd65536;
            end
            rom[k] = FAC_W'(e);
        end
        return rom;
    endfunction

    localparam exp_rom_t EXP_ROM = build_exp_rom();

    function automatic logic [CV_W-1:0] clamp_cv(input logic [15:0] cv);
        if (cv[15]) begin
            return '0;
        end else if (cv[CV_W-1:0] > CV_FULL) begin
            return CV_FULL;
        end else begin
            return cv[CV_W-1:0];
        end
    endfunction

    logic [2:0]           state_reg, state_next;
    logic [15:0]          audio_reg;
    logic [CV_W-1:0]      lin_c_reg, exp_c_reg;
    logic                 lin_en_reg, exp_en_reg, last_reg;
    logic [EXP_IDX_W-1:0] idx_reg;
    logic [CV_W-1:0]      frac_reg;
    logic [FAC_W-1:0]     lin_fac_reg, lo_reg, hi_reg;
    logic [32:0]          prod_reg;

    logic                 in_accept;
    logic [T_W-1:0]       t_val, idx_back, frac_full;
    logic [2*T_W:0]       idx_prod;
    logic [EXP_IDX_W-1:0] idx_q, idx_hi;
    logic [18:0]          lin_y;
    logic [38:0]          lin_prod;
    logic [FAC_W-1:0]     dt;
    logic [32:0]          interp_x;
    logic [21:0]          interp_y;
    logic [44:0]          q_prod;
    logic [18:0]          exp_sum;

    assign in_ready  = (state_reg == F_IDLE) || (state_reg == F_FIN && !q_full);
    assign in_accept = in_valid && in_ready;

    assign t_val     = {exp_c_reg, {EXP_TABLE_BITS{1'b0}}};
    assign idx_prod  = (2*T_W+1)'(t_val) * (2*T_W+1)'(IDX_M);
    assign idx_q     = idx_prod[IDX_SH +: EXP_IDX_W];
    assign idx_back  = T_W'(idx_q) * T_W'(CV_FULL);
    assign frac_full = t_val - idx_back;

    assign lin_y    = {lin_c_reg, 4'b0000} + 19'd2;
    assign lin_prod = 39'(lin_y) * 39'(LIN_M);

    assign idx_hi = (idx_reg == EXP_IDX_LAST) ? idx_reg : idx_reg + 1'b1;

    assign dt       = hi_reg - lo_reg;
    assign interp_x = 33'(dt) * 33'(frac_reg) + 33'd10240;

    assign interp_y = prod_reg[32:11];
    assign q_prod   = 45'(interp_y) * 45'(INT_M);
    assign exp_sum  = {2'b00, lo_reg} + q_prod[44:26];

    assign push_valid        = (state_reg == F_FIN);
    assign push_item.audio   = audio_reg;
    assign push_item.lin_fac = lin_fac_reg;
    assign push_item.lin_en  = lin_en_reg;
    assign push_item.exp_fac = exp_sum[FAC_W-1:0];
    assign push_item.exp_en  = exp_en_reg;
    assign push_item.last    = last_reg;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE: begin
                if (in_accept) begin
                    state_next = F_IDX;
                end
            end
            F_IDX:  state_next = F_RD;
            F_RD:   state_next = F_MUL;
            F_MUL:  state_next = F_FIN;
            F_FIN: begin
                if (!q_full) begin
                    state_next = in_accept ? F_IDX : F_IDLE;
                end
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            audio_reg  <= in_data[15:0];
            lin_c_reg  <= clamp_cv(in_data[31:16]);
            exp_c_reg  <= clamp_cv(in_data[47:32]);
            lin_en_reg <= in_user[0];
            exp_en_reg <= in_user[1];
            last_reg   <= in_last;
        end
        if (state_reg == F_IDX) begin
            idx_reg     <= idx_q;
            frac_reg    <= frac_full[CV_W-1:0];
            lin_fac_reg <= lin_prod[38:22];
        end
        if (state_reg == F_RD) begin
            lo_reg <= EXP_ROM[idx_reg];
            hi_reg <= EXP_ROM[idx_hi];
        end
        if (state_reg == F_MUL) begin
            prod_reg <= interp_x;
        end
    end

endmodule
`default_nettype wire

// ===== sv/vbm_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vbm_queue
// Short first-in first-out buffer of classified items between the two halves.
// ----------------------------------------------------------------------------
module vbm_queue (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               push_valid,
    input  wire vbm_pkg::vbm_item_t push_item,
    output logic                    full,
    input  wire logic               pop,
    output vbm_pkg::vbm_item_t      head,
    output logic                    empty
);
    import vbm_pkg::*;

    vbm_item_t           mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg;
    logic                push_ok;

    assign full    = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign push_ok = push_valid && !full;
    assign head    = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push_ok) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            case ({push_ok, pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (push_ok) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule
`default_nettype wire

// ===== sv/vbm_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vbm_back
// Applies the level factor, then the control factors through one shared
// multiplier, keeps the frame sum, forms the mix outputs and holds the result beat.
// ----------------------------------------------------------------------------
module vbm_back (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               q_empty,
    input  wire vbm_pkg::vbm_item_t q_head,
    output logic                    q_pop,
    input  wire vbm_pkg::vbm_gain_t gains,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [47:0]             out_data,
    output logic                    out_user
);
    import vbm_pkg::*;

    localparam logic [2:0] B_IDLE = 3'd0;
    localparam logic [2:0] B_LIN  = 3'd1;
    localparam logic [2:0] B_EXP  = 3'd2;
    localparam logic [2:0] B_SUM  = 3'd3;
    localparam logic [2:0] B_MIX  = 3'd4;

    localparam logic signed [SUM_W:0] SUM_MAX = 22'sd1048575;
    localparam logic signed [SUM_W:0] SUM_MIN = -22'sd1048576;

    function automatic logic [15:0] sat16(input logic signed [22:0] v);
        if (v > 23'sd32767) begin
            return 16'h7fff;
        end else if (v < -23'sd32768) begin
            return 16'h8000;
        end else begin
            return v[15:0];
        end
    endfunction

    logic [2:0]              state_reg, state_next;
    vbm_item_t               item_reg;
    logic signed [32:0]      acc_reg;
    logic [15:0]             ch_reg;
    logic signed [SUM_W-1:0] sum_reg, mixsum_reg;
    logic                    out_valid_reg;
    logic [15:0]             out_ch_reg, out_m1_reg, out_m2_reg;
    logic                    out_mv_reg;

    logic                    can_load;
    logic signed [32:0]      lvl_prod;
    logic [FAC_W-1:0]        fac_sel;
    logic                    fac_en;
    logic signed [50:0]      mul_prod, mul_rnd;
    logic signed [33:0]      ch_rnd;
    logic signed [17:0]      ch_v;
    logic [15:0]             ch_sat;
    logic signed [SUM_W:0]   sum_add;
    logic signed [SUM_W-1:0] sum_sat;
    logic signed [37:0]      mix1_prod, mix2_prod;
    logic signed [38:0]      mix1_rnd, mix2_rnd;

    assign can_load = !out_valid_reg || out_ready;
    assign q_pop    = !q_empty &&
                      ((state_reg == B_IDLE) || (state_reg == B_MIX && can_load));

    assign lvl_prod = $signed(q_head.audio) * $signed({1'b0, gains.level});

    assign fac_sel  = (state_reg == B_LIN) ? item_reg.lin_fac : item_reg.exp_fac;
    assign fac_en   = (state_reg == B_LIN) ? item_reg.lin_en : item_reg.exp_en;
    assign mul_prod = acc_reg * $signed({1'b0, fac_sel});
    assign mul_rnd  = mul_prod + 51'sd32768;

    assign ch_rnd = {acc_reg[32], acc_reg} + 34'sd32768;
    assign ch_v   = ch_rnd[33:16];
    assign ch_sat = sat16({{5{ch_v[17]}}, ch_v});

    assign sum_add = {sum_reg[SUM_W-1], sum_reg} + {{(SUM_W-15){ch_sat[15]}}, ch_sat};

    always_comb begin
        if (sum_add > SUM_MAX) begin
            sum_sat = SUM_MAX[SUM_W-1:0];
        end else if (sum_add < SUM_MIN) begin
            sum_sat = SUM_MIN[SUM_W-1:0];
        end else begin
            sum_sat = sum_add[SUM_W-1:0];
        end
    end

    assign mix1_prod = mixsum_reg * $signed({1'b0, gains.mix_one});
    assign mix2_prod = mixsum_reg * $signed({1'b0, gains.mix_two});
    assign mix1_rnd  = {mix1_prod[37], mix1_prod} + 39'sd32768;
    assign mix2_rnd  = {mix2_prod[37], mix2_prod} + 39'sd32768;

    assign out_valid = out_valid_reg;
    assign out_data  = {out_m2_reg, out_m1_reg, out_ch_reg};
    assign out_user  = out_mv_reg;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE: begin
                if (q_pop) begin
                    state_next = B_LIN;
                end
            end
            B_LIN:  state_next = B_EXP;
            B_EXP:  state_next = B_SUM;
            B_SUM:  state_next = B_MIX;
            B_MIX: begin
                if (can_load) begin
                    state_next = q_pop ? B_LIN : B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
            sum_reg       <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == B_MIX && can_load) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (state_reg == B_SUM) begin
                sum_reg <= item_reg.last ? '0 : sum_sat;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            item_reg <= q_head;
            acc_reg  <= lvl_prod;
        end else if ((state_reg == B_LIN || state_reg == B_EXP) && fac_en) begin
            acc_reg <= mul_rnd[48:16];
        end
        if (state_reg == B_SUM) begin
            ch_reg     <= ch_sat;
            mixsum_reg <= sum_sat;
        end
        if (state_reg == B_MIX && can_load) begin
            out_ch_reg <= ch_reg;
            out_mv_reg <= item_reg.last;
            // zero mix lanes on beats that do not close a frame
            if (item_reg.last) begin
                out_m1_reg <= sat16(mix1_rnd[38:16]);
                out_m2_reg <= sat16(mix2_rnd[38:16]);
            end else begin
                out_m1_reg <= '0;
                out_m2_reg <= '0;
            end
        end
    end

endmodule
`default_nettype wire

// ===== sv/vca_bank_with_mix.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vca_bank_with_mix
// Voltage-controlled amplifier bank channel with linear and exponential
// control and a running frame mix.
//
//   channel  dir  signals                        content
//   s_       in   tvalid tready tdata tuser tlast one channel sample
//   m_       out  tvalid tready tdata tuser       channel and mix results
//   cfg_     in   wr_en index wdata               gain registers
//
// The front takes each beat through clamp, index divide, ROM read and
// interpolation; the back applies the linear and then the exponential factor
// through its one shared factor multiplier, then forms the sum and the mix.
// Neither half takes a new beat before it is through with the last one.
// Synchronous active-low reset clears control state and frame sum and sets
// the gains to 32768. A four-entry queue lets the front keep accepting while
// the back or the result register is stalled.
// ----------------------------------------------------------------------------
module vca_bank_with_mix (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // audio_sample [15:0], lin_cv [31:16], exp_cv [47:32]
    input  wire logic [47:0]                    s_tdata,
    // lin_connected [0], exp_connected [1]
    input  wire logic [1:0]                     s_tuser,
    input  wire logic                           s_tlast,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // channel_out [15:0], mix_one_out [31:16], mix_two_out [47:32]
    output logic [47:0]                         m_tdata,
    // mix_valid [0]
    output logic                                m_tuser,
    input  wire logic                           cfg_wr_en,
    input  wire logic [vbm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [vbm_pkg::GAIN_W-1:0]     cfg_wdata
);
    import vbm_pkg::*;

    vbm_gain_t gains_reg;
    vbm_item_t push_item, q_head;
    logic      push_valid, q_full, q_pop, q_empty;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gains_reg.level   <= 16'd32768;
            gains_reg.mix_one <= 16'd32768;
            gains_reg.mix_two <= 16'd32768;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_LEVEL:   gains_reg.level   <= cfg_wdata;
                CFG_MIX_ONE: gains_reg.mix_one <= cfg_wdata;
                CFG_MIX_TWO: gains_reg.mix_two <= cfg_wdata;
                default:     gains_reg         <= gains_reg;
            endcase
        end
    end

    vbm_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_data    (s_tdata),
        .in_user    (s_tuser),
        .in_last    (s_tlast),
        .push_valid (push_valid),
        .push_item  (push_item),
        .q_full     (q_full)
    );

    vbm_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_item  (push_item),
        .full       (q_full),
        .pop        (q_pop),
        .head       (q_head),
        .empty      (q_empty)
    );

    vbm_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_empty   (q_empty),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .gains     (gains_reg),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata),
        .out_user  (m_tuser)
    );

endmodule
`default_nettype wire
